### rtl/spgm_pkg.sv
// Shared widths and constants for the stereo pan and gain mixer.
package spgm_pkg;

    // Field widths at the ports.
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 24;

    // Internal widths: folded sample, pan index operand, sine entry.
    localparam int MIX_W    = SAMPLE_W + 1;
    localparam int UPAN_W   = 15;
    localparam int SINE_W   = 15;

    // Digit-serial multiplier: signed multiplicand by signed multiplier.
    localparam int DIGIT_W  = 4;
    localparam int MUL_A_W  = 18;
    localparam int MUL_B_W  = 16;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    // Accumulator width.
    localparam int ACC_W    = 40;

    // Fraction bits of the pan law and of the gain.
    localparam int PAN_SH   = 14;
    localparam int GAIN_SH  = 12;

    // Default resolution of the pan table, and pi/2 in Q2.30.
    localparam int PAN_STEPS_DEFAULT = 256;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

endpackage

### rtl/spgm_sine_rom.sv
// Quarter-wave sine table with a registered read port.
module spgm_sine_rom #(
    parameter int PAN_STEPS = spgm_pkg::PAN_STEPS_DEFAULT
) (
    input  logic                                  clk,
    input  logic [$clog2(PAN_STEPS + 1)-1:0]      addr,
    output logic [spgm_pkg::SINE_W-1:0]           data
);
    import spgm_pkg::*;

    typedef logic [SINE_W-1:0] rom_t [0:PAN_STEPS];

    // Entry k is sin(k*pi/(2*PAN_STEPS)) in Q1.14, from a Taylor series in Q2.30.
    function automatic rom_t build_table();
        rom_t              tbl;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   prod;
        longint            sum;
        begin
            for (int k = 0; k <= PAN_STEPS; k++)
            begin
                x    = (longint'(k) * HALF_PI_Q30) / PAN_STEPS;
                x2   = (x * x) >> 30;
                term = x;
                sum  = longint'(x);
                for (int n = 1; n <= 7; n++)
                begin
                    prod = (term * x2) >> 30;
                    case (n)
                        1:       term = prod / 6;
                        2:       term = prod / 20;
                        3:       term = prod / 42;
                        4:       term = prod / 72;
                        5:       term = prod / 110;
                        6:       term = prod / 156;
                        default: term = prod / 210;
                    endcase
                    if (n % 2 == 1)
                    begin
                        sum = sum - longint'(term);
                    end
                    else
                    begin
                        sum = sum + longint'(term);
                    end
                end
                if (sum < 0)
                begin
                    sum = 0;
                end
                sum = (sum + 32768) >>> 16;
                if (sum > 16384)
                begin
                    sum = 16384;
                end
                tbl[k] = SINE_W'(sum);
            end
            return tbl;
        end
    endfunction

    localparam rom_t SINE_TABLE = build_table();

    logic [SINE_W-1:0] data_reg;

    // Registered table read.
    always_ff @(posedge clk)
    begin
        data_reg <= SINE_TABLE[addr];
    end

    assign data = data_reg;

endmodule

### rtl/spgm_serial_mul.sv
// Digit-serial signed multiplier, one 4-bit digit of the multiplier per cycle.
module spgm_serial_mul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [spgm_pkg::MUL_A_W-1:0]  a,
    input  logic signed [spgm_pkg::MUL_B_W-1:0]  b,
    output logic                                 done,
    output logic signed [spgm_pkg::PROD_W-1:0]   product
);
    import spgm_pkg::*;

    localparam int DIGITS = MUL_B_W / DIGIT_W;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam int STEP_W = MUL_A_W + DIGIT_W + 1;

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_B_W-1:0]        b_reg, b_next;
    logic signed [MUL_A_W:0]   hi_reg, hi_next;
    logic [MUL_B_W-1:0]        lo_reg, lo_next;

    logic                      last_digit;
    logic signed [DIGIT_W:0]   digit;
    logic signed [STEP_W-1:0]  partial;
    logic signed [STEP_W-1:0]  step_sum;

    // The top digit carries the sign of the multiplier; the others are unsigned.
    assign last_digit = (cnt_reg == CNT_W'(DIGITS - 1));
    assign digit      = last_digit ? {b_reg[DIGIT_W-1], b_reg[DIGIT_W-1:0]}
                                   : {1'b0, b_reg[DIGIT_W-1:0]};
    assign partial    = a_reg * digit;
    assign step_sum   = STEP_W'(hi_reg) + partial;

    // Load on start, then add one partial product and shift per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            b_next    = b;
            hi_next   = '0;
        end
        else if (busy_reg)
        begin
            hi_next  = step_sum[STEP_W-1:DIGIT_W];
            lo_next  = {step_sum[DIGIT_W-1:0], lo_reg[MUL_B_W-1:DIGIT_W]};
            b_next   = b_reg >> DIGIT_W;
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_digit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial-product shift registers.
    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg[MUL_A_W-1:0], lo_reg};

endmodule

### rtl/stereo_pan_gain_mixer.sv
// Stereo pan and gain mixer: one source frame per item, a saturated mix on the last source.
// Each item carries one source's stereo sample, gain (Q4.12), pan (Q2.14, 0 is center)
// and mono-fold and last-source flags. The block applies a sine/cosine balance law read
// from a quarter-wave table of PAN_STEPS+1 entries, scales by gain and adds into 40-bit
// saturating accumulators; an item with last_source set produces one result with both
// sides saturated to 24 bits and clears the accumulators. The block works on one item
// at a time: it stalls the input while an item is in flight, through two reads of the
// single sine table port and two passes of the 4-bit digit-serial multipliers. A last
// item also waits while the previous mix has not been taken from the output register.
module stereo_pan_gain_mixer #(
    parameter int PAN_STEPS = spgm_pkg::PAN_STEPS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [spgm_pkg::SAMPLE_W-1:0]    left_sample,
    input  logic signed [spgm_pkg::SAMPLE_W-1:0]    right_sample,
    input  logic signed [spgm_pkg::SAMPLE_W-1:0]    source_gain,
    input  logic signed [spgm_pkg::SAMPLE_W-1:0]    pan_position,
    input  logic                                    mono_fold,
    input  logic                                    last_source,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [spgm_pkg::OUT_W-1:0]       mix_left,
    output logic signed [spgm_pkg::OUT_W-1:0]       mix_right
);
    import spgm_pkg::*;

    localparam int IDX_W     = $clog2(PAN_STEPS + 1);
    localparam int KPROD_W   = UPAN_W + IDX_W;
    localparam int PAN_RES_W = PROD_W + 1 - PAN_SH;
    localparam int CONTRIB_W = PROD_W + 1 - GAIN_SH;

    localparam logic signed [SAMPLE_W-1:0] PAN_FULL     = SAMPLE_W'(1) << PAN_SH;
    localparam logic signed [SAMPLE_W-1:0] PAN_FULL_NEG = -PAN_FULL;
    localparam logic signed [PROD_W:0]     PAN_RND      = (PROD_W + 1)'(1) << (PAN_SH - 1);
    localparam logic signed [PROD_W:0]     GAIN_RND     = (PROD_W + 1)'(1) << (GAIN_SH - 1);
    localparam logic signed [ACC_W-1:0]    ACC_HI = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0]    ACC_LO = {1'b1, {(ACC_W - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0]    OUT_HI =
        {{(ACC_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0]    OUT_LO =
        {{(ACC_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIN,
        ST_COS,
        ST_PAN_GO,
        ST_PAN,
        ST_GAIN_GO,
        ST_GAIN,
        ST_ACC,
        ST_OUT
    } state_t;

    // Saturate a sum to the accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        begin
            if (v[ACC_W] != v[ACC_W-1])
            begin
                return v[ACC_W] ? ACC_LO : ACC_HI;
            end
            return v[ACC_W-1:0];
        end
    endfunction

    // Clip an accumulator to the output range.
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        begin
            if (v > OUT_HI)
            begin
                return OUT_HI[OUT_W-1:0];
            end
            if (v < OUT_LO)
            begin
                return OUT_LO[OUT_W-1:0];
            end
            return v[OUT_W-1:0];
        end
    endfunction

    state_t                       state_reg, state_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0]      acc_l_reg, acc_l_next;
    logic signed [ACC_W-1:0]      acc_r_reg, acc_r_next;

    logic signed [MIX_W-1:0]      l_reg, r_reg;
    logic signed [SAMPLE_W-1:0]   gain_reg;
    logic                         last_reg;
    logic                         right_reg;
    logic [UPAN_W-1:0]            u_reg;
    logic [IDX_W-1:0]             k_reg;
    logic [SINE_W-1:0]            sin_reg;
    logic signed [MUL_A_W-1:0]    pl_reg, pr_reg;
    logic signed [CONTRIB_W-1:0]  con_l_reg, con_r_reg;
    logic signed [OUT_W-1:0]      mix_l_reg, mix_r_reg;

    logic                         accept;
    logic                         out_load;
    logic signed [MIX_W-1:0]      fold_sum;
    logic signed [SAMPLE_W-1:0]   pan_clamped;
    logic                         pan_right;
    logic [UPAN_W-1:0]            pan_u;
    logic [KPROD_W-1:0]           k_prod;
    logic [IDX_W-1:0]             k_calc;
    logic [IDX_W-1:0]             rom_addr;
    logic [SINE_W-1:0]            rom_data;
    logic                         mul_start;
    logic                         gain_pass;
    logic signed [MUL_A_W-1:0]    pan_src;
    logic signed [MUL_A_W-1:0]    mul_a_l, mul_a_r;
    logic signed [MUL_B_W-1:0]    mul_b_l, mul_b_r;
    logic                         done_l, done_r, mul_done;
    logic signed [PROD_W-1:0]     prod_l, prod_r;
    logic signed [PROD_W:0]       pan_sum_l, pan_sum_r;
    logic signed [PROD_W:0]       gain_sum_l, gain_sum_r;
    logic signed [PAN_RES_W-1:0]  rnd_l, rnd_r;
    logic signed [PAN_RES_W-1:0]  pl_full, pr_full;

    // Input handshake: one item in flight.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // Mono fold and pan clamp on the incoming item.
    assign fold_sum = MIX_W'(left_sample) + MIX_W'(right_sample);

    always_comb
    begin
        if (pan_position > PAN_FULL)
        begin
            pan_clamped = PAN_FULL;
        end
        else if (pan_position < PAN_FULL_NEG)
        begin
            pan_clamped = PAN_FULL_NEG;
        end
        else
        begin
            pan_clamped = pan_position;
        end
    end

    assign pan_right = (pan_clamped > 0);
    assign pan_u     = pan_right ? pan_clamped[UPAN_W-1:0]
                                 : UPAN_W'(pan_clamped + PAN_FULL);

    // Table index, rounded to the nearest step.
    assign k_prod   = (KPROD_W'(u_reg) * KPROD_W'(PAN_STEPS)) + (KPROD_W'(1) << (PAN_SH - 1));
    assign k_calc   = k_prod[PAN_SH +: IDX_W];
    assign rom_addr = (state_reg == ST_COS) ? (IDX_W'(PAN_STEPS) - k_reg) : k_calc;

    spgm_sine_rom #(
        .PAN_STEPS (PAN_STEPS)
    ) u_sine_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // Operand selection: pan pass scales the far-side sample, gain pass the panned sides.
    assign gain_pass = (state_reg == ST_GAIN_GO);
    assign mul_start = (state_reg == ST_PAN_GO) || gain_pass;
    assign pan_src   = right_reg ? MUL_A_W'(l_reg) : MUL_A_W'(r_reg);
    assign mul_a_l   = gain_pass ? pl_reg : pan_src;
    assign mul_a_r   = gain_pass ? pr_reg : pan_src;
    assign mul_b_l   = gain_pass ? gain_reg : MUL_B_W'(rom_data);
    assign mul_b_r   = gain_pass ? gain_reg : MUL_B_W'(sin_reg);

    spgm_serial_mul u_mul_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a_l),
        .b       (mul_b_l),
        .done    (done_l),
        .product (prod_l)
    );

    spgm_serial_mul u_mul_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a_r),
        .b       (mul_b_r),
        .done    (done_r),
        .product (prod_r)
    );

    assign mul_done = done_l && done_r;

    // Round the pan products and add the near-side sample.
    assign pan_sum_l = (PROD_W + 1)'(prod_l) + PAN_RND;
    assign pan_sum_r = (PROD_W + 1)'(prod_r) + PAN_RND;
    assign rnd_l     = pan_sum_l[PROD_W:PAN_SH];
    assign rnd_r     = pan_sum_r[PROD_W:PAN_SH];
    assign pl_full   = right_reg ? rnd_l : (rnd_l + PAN_RES_W'(l_reg));
    assign pr_full   = right_reg ? (rnd_r + PAN_RES_W'(r_reg)) : rnd_r;

    // Round the gain products.
    assign gain_sum_l = (PROD_W + 1)'(prod_l) + GAIN_RND;
    assign gain_sum_r = (PROD_W + 1)'(prod_r) + GAIN_RND;

    // Sequencer next state, accumulators and output valid.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SIN;
                end
            end
            ST_SIN:     state_next = ST_COS;
            ST_COS:     state_next = ST_PAN_GO;
            ST_PAN_GO:  state_next = ST_PAN;
            ST_PAN:
            begin
                if (mul_done)
                begin
                    state_next = ST_GAIN_GO;
                end
            end
            ST_GAIN_GO: state_next = ST_GAIN;
            ST_GAIN:
            begin
                if (mul_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_l_next = sat_acc((ACC_W + 1)'(acc_l_reg) + (ACC_W + 1)'(con_l_reg));
                acc_r_next = sat_acc((ACC_W + 1)'(acc_r_reg) + (ACC_W + 1)'(con_r_reg));
                state_next = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    acc_l_next     = '0;
                    acc_r_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // State, accumulators and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_l_reg     <= '0;
            acc_r_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_l_reg     <= acc_l_next;
            acc_r_reg     <= acc_r_next;
        end
    end

    // Item payload and intermediate results.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            l_reg     <= mono_fold ? fold_sum : MIX_W'(left_sample);
            r_reg     <= mono_fold ? fold_sum : MIX_W'(right_sample);
            gain_reg  <= source_gain;
            last_reg  <= last_source;
            right_reg <= pan_right;
            u_reg     <= pan_u;
        end
        if (state_reg == ST_SIN)
        begin
            k_reg <= k_calc;
        end
        if (state_reg == ST_COS)
        begin
            sin_reg <= rom_data;
        end
        if ((state_reg == ST_PAN) && mul_done)
        begin
            pl_reg <= pl_full[MUL_A_W-1:0];
            pr_reg <= pr_full[MUL_A_W-1:0];
        end
        if ((state_reg == ST_GAIN) && mul_done)
        begin
            con_l_reg <= gain_sum_l[PROD_W:GAIN_SH];
            con_r_reg <= gain_sum_r[PROD_W:GAIN_SH];
        end
        if (out_load)
        begin
            mix_l_reg <= sat_out(acc_l_reg);
            mix_r_reg <= sat_out(acc_r_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign mix_left  = mix_l_reg;
    assign mix_right = mix_r_reg;

endmodule
